[rtl/core/sbda_pkg.sv]
// Shared constants, types and cell controls for the signed binary to decimal ASCII converter.
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

    localparam int DATA_W      = 32;
    localparam int CHAR_W      = 7;
    localparam int DIGIT_W     = 4;
    localparam int DIGIT_CELLS = 10;
    localparam int MAX_DIGITS  = 10;
    localparam int EMIT_DIGITS = (MAX_DIGITS < DIGIT_CELLS) ? MAX_DIGITS : DIGIT_CELLS;
    localparam int SHIFT_W     = $clog2(DATA_W);
    localparam int REMAIN_W    = $clog2(DIGIT_CELLS + 1);

    localparam logic [SHIFT_W-1:0]  SHIFT_LAST = SHIFT_W'(DATA_W - 1);
    localparam logic [REMAIN_W-1:0] REMAIN_ALL = REMAIN_W'(DIGIT_CELLS);
    localparam logic [REMAIN_W-1:0] REMAIN_ONE = REMAIN_W'(1);
    localparam logic [REMAIN_W-1:0] REMAIN_WIN = REMAIN_W'(EMIT_DIGITS);

    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ     = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 4'd0;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'd57;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    typedef struct packed {
        logic clear;
        logic dbl;
        logic move;
    } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/core/sbda_digit_cell.sv]
// One BCD digit cell: clear, shift-add-3 doubling step and digit move toward the top.
`timescale 1ns / 1ps
`default_nettype none

module sbda_digit_cell (
    input  wire logic                        aclk,
    input  wire sbda_pkg::cell_ctrl_t        ctrl,
    input  wire logic                        bit_in,
    input  wire logic [sbda_pkg::DIGIT_W-1:0] digit_in,
    output logic                             bit_out,
    output logic [sbda_pkg::DIGIT_W-1:0]     digit_out
);

    logic [sbda_pkg::DIGIT_W-1:0] digit_reg;
    logic [sbda_pkg::DIGIT_W-1:0] digit_next;
    logic [sbda_pkg::DIGIT_W-1:0] adj;

    always_comb begin
        adj = (digit_reg >= sbda_pkg::BCD_ADJ_MIN) ? digit_reg + sbda_pkg::BCD_ADJ : digit_reg;
    end

    always_comb begin
        digit_next = digit_reg;
        if (ctrl.clear) begin
            digit_next = sbda_pkg::DIGIT_ZERO;
        end else if (ctrl.dbl) begin
            digit_next = {adj[sbda_pkg::DIGIT_W-2:0], bit_in};
        end else if (ctrl.move) begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge aclk) begin
        digit_reg <= digit_next;
    end

    assign bit_out   = adj[sbda_pkg::DIGIT_W-1];
    assign digit_out = digit_reg;

endmodule

`default_nettype wire

[rtl/core/sbda_cell_chain.sv]
// Row of BCD digit cells, least significant digit at cell zero.
`timescale 1ns / 1ps
`default_nettype none

module sbda_cell_chain (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire sbda_pkg::cell_ctrl_t        ctrl,
    input  wire logic                        bit_in,
    output logic [sbda_pkg::DIGIT_W-1:0]     top_digit
);

    logic [sbda_pkg::DIGIT_CELLS-1:0]     carry;
    logic [sbda_pkg::DIGIT_W-1:0]         digit [sbda_pkg::DIGIT_CELLS];
    logic [sbda_pkg::DIGIT_W-1:0]         digit_feed [sbda_pkg::DIGIT_CELLS];
    logic                                 top_carry;

    assign carry[0]      = bit_in;
    assign digit_feed[0] = sbda_pkg::DIGIT_ZERO;

    for (genvar i = 0; i < sbda_pkg::DIGIT_CELLS; i++) begin : g_cell
        logic cell_carry;

        sbda_digit_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .bit_in    (carry[i]),
            .digit_in  (digit_feed[i]),
            .bit_out   (cell_carry),
            .digit_out (digit[i])
        );

        if (i < sbda_pkg::DIGIT_CELLS - 1) begin : g_link
            assign carry[i+1]      = cell_carry;
            assign digit_feed[i+1] = digit[i];
        end else begin : g_top
            assign top_carry = cell_carry;
        end
    end

    assign top_digit = digit[sbda_pkg::DIGIT_CELLS-1];

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.dbl |-> !top_carry)
        else $error("decimal overflow out of top cell");

    a_one_op: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones({ctrl.clear, ctrl.dbl, ctrl.move}) <= 1)
        else $error("conflicting cell operations");

endmodule

`default_nettype wire

[rtl/core/signed_binary_to_decimal_ascii.sv]
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// Input channel s_valid/s_ready/s_value takes one signed integer per request.
// Output channel m_valid/m_ready/m_character/m_last emits its decimal text,
// most significant character first: '-' for negative values, then digits
// with no leading zeros ("0" for zero). m_last marks the final character.
// Conversion runs one shift-add-3 step per magnitude bit through a row of
// ten BCD digit cells, then the digits move one cell per cycle, unless stalled,
// toward the top cell, which feeds the output register. One number passes
// through a load step, the conversion, a sign step when negative and the
// digit walk. Leading zero cells of a shorter positive value are walked past
// without output before its first character. s_ready is high only while
// idle; the next request may enter while the final character still waits
// in the output register.
// A low m_ready holds the output register and stalls the digit walk.
// aresetn (synchronous, active low) drops any number in progress and
// clears the output valid.
`timescale 1ns / 1ps
`default_nettype none

module signed_binary_to_decimal_ascii (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [sbda_pkg::DATA_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [sbda_pkg::CHAR_W-1:0]            m_character,
    output logic                                   m_last
);

    sbda_pkg::state_t                 state_reg, state_next;
    logic [sbda_pkg::DATA_W-1:0]      mag_reg, mag_next;
    logic                             neg_reg, neg_next;
    logic [sbda_pkg::SHIFT_W-1:0]     shift_cnt_reg, shift_cnt_next;
    logic [sbda_pkg::REMAIN_W-1:0]    remain_reg, remain_next;
    logic                             leading_reg, leading_next;
    logic                             m_valid_reg, m_valid_next;
    logic [sbda_pkg::CHAR_W-1:0]      m_character_reg, m_character_next;
    logic                             m_last_reg, m_last_next;

    sbda_pkg::cell_ctrl_t             cell_ctrl;
    logic [sbda_pkg::DIGIT_W-1:0]     top_digit;
    logic                             out_free;
    logic                             digit_zero;
    logic                             skip_lead;
    logic                             in_window;
    logic                             emit_digit;
    logic                             digit_step;
    logic                             out_load;

    sbda_cell_chain u_chain (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (cell_ctrl),
        .bit_in    (mag_reg[sbda_pkg::DATA_W-1]),
        .top_digit (top_digit)
    );

    assign out_free   = !m_valid_reg || m_ready;
    assign digit_zero = (top_digit == sbda_pkg::DIGIT_ZERO);
    assign skip_lead  = leading_reg && digit_zero && (remain_reg != sbda_pkg::REMAIN_ONE);
    assign in_window  = (remain_reg <= sbda_pkg::REMAIN_WIN);
    assign emit_digit = (state_reg == sbda_pkg::ST_DIGITS) && !skip_lead && in_window;
    assign digit_step = (state_reg == sbda_pkg::ST_DIGITS) && (!emit_digit || out_free);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sbda_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = sbda_pkg::ST_CONVERT;
                end
            end
            sbda_pkg::ST_CONVERT: begin
                if (shift_cnt_reg == sbda_pkg::SHIFT_LAST) begin
                    state_next = neg_reg ? sbda_pkg::ST_SIGN : sbda_pkg::ST_DIGITS;
                end
            end
            sbda_pkg::ST_SIGN: begin
                if (out_free) begin
                    state_next = sbda_pkg::ST_DIGITS;
                end
            end
            sbda_pkg::ST_DIGITS: begin
                if (digit_step && (remain_reg == sbda_pkg::REMAIN_ONE)) begin
                    state_next = sbda_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sbda_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        cell_ctrl        = '0;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        shift_cnt_next   = shift_cnt_reg;
        remain_next      = remain_reg;
        leading_next     = leading_reg;
        out_load         = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_character_next = m_character_reg;
        m_last_next      = m_last_reg;
        case (state_reg)
            sbda_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    neg_next       = s_value[sbda_pkg::DATA_W-1];
                    mag_next       = s_value[sbda_pkg::DATA_W-1]
                                     ? (~$unsigned(s_value) + 32'd1) : $unsigned(s_value);
                    shift_cnt_next = '0;
                    cell_ctrl.clear = 1'b1;
                end
            end
            sbda_pkg::ST_CONVERT: begin
                cell_ctrl.dbl  = 1'b1;
                mag_next       = {mag_reg[sbda_pkg::DATA_W-2:0], 1'b0};
                shift_cnt_next = shift_cnt_reg + 1'b1;
                remain_next    = sbda_pkg::REMAIN_ALL;
                leading_next   = 1'b1;
            end
            sbda_pkg::ST_SIGN: begin
                if (out_free) begin
                    out_load         = 1'b1;
                    m_character_next = sbda_pkg::CHAR_MINUS;
                    m_last_next      = 1'b0;
                end
            end
            sbda_pkg::ST_DIGITS: begin
                if (digit_step) begin
                    cell_ctrl.move = 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    if (!digit_zero) begin
                        leading_next = 1'b0;
                    end
                    if (emit_digit) begin
                        out_load         = 1'b1;
                        m_character_next = sbda_pkg::CHAR_ZERO + {3'b000, top_digit};
                        m_last_next      = (remain_reg == sbda_pkg::REMAIN_ONE);
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sbda_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg         <= mag_next;
        neg_reg         <= neg_next;
        shift_cnt_reg   <= shift_cnt_next;
        remain_reg      <= remain_next;
        leading_reg     <= leading_next;
        m_character_reg <= m_character_next;
        m_last_reg      <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_character = m_character_reg;
    assign m_last      = m_last_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == sbda_pkg::ST_CONVERT)
        else $error("request did not start conversion");

    a_remain_live: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == sbda_pkg::ST_DIGITS |-> remain_reg != '0)
        else $error("digit walk ran past the bottom cell");

    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load && m_last_next |=> state_reg == sbda_pkg::ST_IDLE)
        else $error("final character without return to idle");

    a_char_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_character == sbda_pkg::CHAR_MINUS && !m_last) ||
                    (m_character >= sbda_pkg::CHAR_ZERO &&
                     m_character <= sbda_pkg::CHAR_NINE))
        else $error("illegal output character");

endmodule

`default_nettype wire
